/* rtl/core/first_fit_heap_allocator_assert.svh */
// Assertion macros used by the allocator checker.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define FFHA_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define FFHA_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/ffha_pkg.sv */
// Shared constants and types for the first-fit heap allocator.
// Depends on nothing; imported by every allocator module.
package ffha_pkg;

    localparam int MAX_BLOCKS_DEF   = 64;
    localparam int ALIGN_BYTES_DEF  = 16;
    localparam int HEADER_BYTES_DEF = 24;

    // Width of internal address arithmetic: header + size + padding never wraps
    localparam int VAL_W = 36;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOSPACE  = 3'd1;
    localparam logic [2:0] ST_OVERLAP  = 3'd2;
    localparam logic [2:0] ST_UNKNOWN  = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    localparam logic CFG_HEAP_BASE  = 1'b0;
    localparam logic CFG_HEAP_LIMIT = 1'b1;

    // Result of the alignment unit
    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] value;
    } align_rsp_t;

endpackage

/* rtl/core/ffha_table.sv */
// Block table storage: header address and data size memories.
// Depends on ffha_pkg; one write port, one registered read port.
module ffha_table
    import ffha_pkg::*;
#(
    parameter int DEPTH = MAX_BLOCKS_DEF,
    parameter int AW    = $clog2(MAX_BLOCKS_DEF)
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   whdr,
    input  logic [31:0]   wsize,
    input  logic [AW-1:0] raddr,
    output logic [31:0]   rhdr,
    output logic [31:0]   rsize
);

    logic [31:0] hdr_mem  [DEPTH];
    logic [31:0] size_mem [DEPTH];

    // Write both fields of one entry
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            hdr_mem[waddr]  <= whdr;
            size_mem[waddr] <= wsize;
        end
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        rhdr  <= hdr_mem[raddr];
        rsize <= size_mem[raddr];
    end

endmodule

/* rtl/core/ffha_align.sv */
// Round-up-to-alignment unit: add and mask, ALIGN_BYTES a power of two.
// Depends on ffha_pkg; result and done are registered and valid in the cycle after start.
module ffha_align
    import ffha_pkg::*;
#(
    parameter int ALIGN_BYTES = ALIGN_BYTES_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [VAL_W-1:0] value,
    output align_rsp_t       rsp
);

    localparam logic [VAL_W-1:0] PAD_V  = VAL_W'(ALIGN_BYTES - 1);
    localparam logic [VAL_W-1:0] MASK_V = ~PAD_V;

    logic             done_reg;
    logic [VAL_W-1:0] res_reg;

    // Pad up to the next multiple and drop the low bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            res_reg  <= '0;
        end
        else
        begin
            done_reg <= start;
            if (start)
                res_reg <= (value + PAD_V) & MASK_V;
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.value = res_reg;

endmodule

/* rtl/core/first_fit_heap_allocator.sv */
// First-fit heap allocator top level: request sequencer over the block table.
// Depends on ffha_pkg, ffha_table and ffha_align.
//
// Usage:
//   Request channel: drive req_type, req_size, release_address and raise start;
//   the transfer happens at a clock edge with start high and busy low. busy then
//   stays high until the result. The result (data_address, status) is shown for
//   exactly one cycle with done high; the receiver cannot stall it, and a new
//   request may be taken in that same done cycle.
//   Config channel: cfg_valid/cfg_ready with cfg_index (0 heap base,
//   1 heap limit) and cfg_data; cfg_ready is always high. Write only while idle.
// Timing: an allocate walks the table entries, runs the alignment unit for each
//   hole or append candidate and, on a fit, moves entries up to open a slot; a
//   release walks the entries and, unless it frees the head, moves the later
//   entries down. The first allocation needs no walk; an early reject of a
//   release answers in the cycle after the transfer without raising busy.
//   ALIGN_BYTES must be a power of two.
// Reset: table empty, head pending, heap base 0, heap limit all ones. The
//   table memories need no clearing; entries beyond the count are never read.
module first_fit_heap_allocator
    import ffha_pkg::*;
#(
    parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
    parameter int ALIGN_BYTES  = ALIGN_BYTES_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        req_type,
    input  logic [31:0] req_size,
    input  logic [31:0] release_address,
    output logic        done,
    output logic [31:0] data_address,
    output logic [2:0]  status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int AW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [VAL_W-1:0] HDR_V  = VAL_W'(HEADER_BYTES);
    localparam logic [31:0]      HDR_32 = 32'(HEADER_BYTES);
    localparam logic [CW-1:0]    MAX_C  = CW'(MAX_BLOCKS);

    typedef enum logic [3:0] {
        S_IDLE, S_RDC, S_CUR, S_NXT, S_ALIGN, S_SHR, S_SHW, S_INS,
        S_RRD, S_RCMP, S_DRD, S_DWR
    } state_t;

    typedef enum logic [1:0] {
        M_FIRST, M_HOLE, M_APPEND
    } mode_t;

    state_t      state_reg, state_next;
    mode_t       mode_reg, mode_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [CW-1:0] count_reg, count_next;
    logic        head_free_reg, head_free_next;
    logic        first_pend_reg, first_pend_next;
    logic [31:0] head_addr_reg, head_addr_next;
    logic [31:0] limit_reg, limit_next;
    logic [31:0] size_reg, size_next;
    logic [31:0] target_reg, target_next;
    logic [31:0] cur_h_reg, cur_h_next;
    logic [31:0] cur_s_reg, cur_s_next;
    logic [31:0] nxt_h_reg, nxt_h_next;
    logic [31:0] hdr_reg, hdr_next;
    logic [31:0] data_reg, data_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [31:0] addr_out_reg, addr_out_next;
    logic [2:0]  st_reg, st_next;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0]   mem_whdr;
    logic [31:0]   mem_wsize;
    logic [AW-1:0] mem_raddr;
    logic [31:0]   rd_hdr;
    logic [31:0]   rd_size;

    logic             al_start;
    logic [VAL_W-1:0] al_value;
    align_rsp_t       al_rsp;

    logic [VAL_W-1:0] rd_end;
    logic [VAL_W-1:0] rd_need;
    logic [VAL_W-1:0] cur_end;
    logic [VAL_W-1:0] al_need;
    logic [VAL_W-1:0] limit_v;
    logic [CW-1:0]    idx_p1;

    ffha_table #(
        .DEPTH (MAX_BLOCKS),
        .AW    (AW)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .whdr  (mem_whdr),
        .wsize (mem_wsize),
        .raddr (mem_raddr),
        .rhdr  (rd_hdr),
        .rsize (rd_size)
    );

    ffha_align #(
        .ALIGN_BYTES (ALIGN_BYTES)
    ) u_align (
        .clk   (clk),
        .rst_n (rst_n),
        .start (al_start),
        .value (al_value),
        .rsp   (al_rsp)
    );

    // Address arithmetic shared by the walk states
    assign rd_end  = VAL_W'(rd_hdr) + HDR_V + VAL_W'(rd_size);
    assign rd_need = VAL_W'(rd_hdr) + HDR_V + VAL_W'(size_reg);
    assign cur_end = VAL_W'(cur_h_reg) + HDR_V + VAL_W'(cur_s_reg);
    assign al_need = al_rsp.value + VAL_W'(size_reg);
    assign limit_v = VAL_W'(limit_reg);
    assign idx_p1  = CW'(idx_reg) + CW'(1);

    // Sequencer: walk, align, shift and answer
    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        count_next      = count_reg;
        head_free_next  = head_free_reg;
        first_pend_next = first_pend_reg;
        head_addr_next  = head_addr_reg;
        limit_next      = limit_reg;
        size_next       = size_reg;
        target_next     = target_reg;
        cur_h_next      = cur_h_reg;
        cur_s_next      = cur_s_reg;
        nxt_h_next      = nxt_h_reg;
        hdr_next        = hdr_reg;
        data_next       = data_reg;
        busy_next       = busy_reg;
        done_next       = 1'b0;
        addr_out_next   = addr_out_reg;
        st_next         = st_reg;
        mem_we          = 1'b0;
        mem_waddr       = idx_reg;
        mem_whdr        = rd_hdr;
        mem_wsize       = rd_size;
        mem_raddr       = idx_reg;
        al_start        = 1'b0;
        al_value        = rd_end + HDR_V;

        // Configuration writes
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_HEAP_BASE:
                begin
                    if (first_pend_reg)
                        head_addr_next = cfg_data;
                end
                CFG_HEAP_LIMIT:
                    limit_next = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start && !busy_reg)
                begin
                    size_next = req_size;
                    idx_next  = '0;
                    if (req_type == REQ_ALLOC)
                    begin
                        busy_next = 1'b1;
                        if (first_pend_reg || count_reg == '0)
                        begin
                            al_start   = 1'b1;
                            al_value   = VAL_W'(head_addr_reg) + HDR_V;
                            mode_next  = M_FIRST;
                            state_next = S_ALIGN;
                        end
                        else
                            state_next = S_RDC;
                    end
                    else if (first_pend_reg || count_reg == '0 || release_address < HDR_32)
                    begin
                        done_next     = 1'b1;
                        st_next       = ST_UNKNOWN;
                        addr_out_next = '0;
                    end
                    else
                    begin
                        busy_next   = 1'b1;
                        target_next = release_address - HDR_32;
                        state_next  = S_RRD;
                    end
                end
            end

            S_RDC:
                state_next = S_CUR;

            S_CUR:
            begin
                cur_h_next = rd_hdr;
                cur_s_next = rd_size;
                priority if (idx_reg == '0 && head_free_reg && count_reg == CW'(1)
                             && rd_need > limit_v)
                begin
                    done_next     = 1'b1;
                    busy_next     = 1'b0;
                    st_next       = ST_NOSPACE;
                    addr_out_next = '0;
                    state_next    = S_IDLE;
                end
                else if (idx_reg == '0 && head_free_reg
                         && (count_reg == CW'(1) || size_reg <= rd_size))
                begin
                    // Reuse the released head in place
                    mem_we         = 1'b1;
                    mem_waddr      = '0;
                    mem_whdr       = rd_hdr;
                    mem_wsize      = size_reg;
                    head_free_next = 1'b0;
                    done_next      = 1'b1;
                    busy_next      = 1'b0;
                    st_next        = ST_OK;
                    addr_out_next  = rd_hdr + HDR_32;
                    state_next     = S_IDLE;
                end
                else if (idx_p1 < count_reg)
                begin
                    mem_raddr  = AW'(idx_p1);
                    state_next = S_NXT;
                end
                else
                begin
                    al_start   = 1'b1;
                    al_value   = rd_end + HDR_V;
                    mode_next  = M_APPEND;
                    state_next = S_ALIGN;
                end
            end

            S_NXT:
            begin
                nxt_h_next = rd_hdr;
                priority if (cur_end < VAL_W'(rd_hdr))
                begin
                    al_start   = 1'b1;
                    al_value   = cur_end + HDR_V;
                    mode_next  = M_HOLE;
                    state_next = S_ALIGN;
                end
                else if (cur_end > VAL_W'(rd_hdr))
                begin
                    done_next     = 1'b1;
                    busy_next     = 1'b0;
                    st_next       = ST_OVERLAP;
                    addr_out_next = '0;
                    state_next    = S_IDLE;
                end
                else
                begin
                    idx_next   = AW'(idx_p1);
                    state_next = S_RDC;
                end
            end

            S_ALIGN:
            begin
                if (al_rsp.done)
                begin
                    hdr_next  = 32'(al_rsp.value - HDR_V);
                    data_next = al_rsp.value[31:0];
                    unique case (mode_reg)
                        M_FIRST:
                        begin
                            done_next     = 1'b1;
                            busy_next     = 1'b0;
                            state_next    = S_IDLE;
                            if (al_need > limit_v)
                            begin
                                st_next       = ST_NOSPACE;
                                addr_out_next = '0;
                            end
                            else
                            begin
                                mem_we          = 1'b1;
                                mem_waddr       = '0;
                                mem_whdr        = 32'(al_rsp.value - HDR_V);
                                mem_wsize       = size_reg;
                                count_next      = CW'(1);
                                head_addr_next  = 32'(al_rsp.value - HDR_V);
                                head_free_next  = 1'b0;
                                first_pend_next = 1'b0;
                                st_next         = ST_OK;
                                addr_out_next   = al_rsp.value[31:0];
                            end
                        end
                        M_HOLE:
                        begin
                            priority if (al_need <= VAL_W'(nxt_h_reg) && count_reg >= MAX_C)
                            begin
                                done_next     = 1'b1;
                                busy_next     = 1'b0;
                                st_next       = ST_FULL;
                                addr_out_next = '0;
                                state_next    = S_IDLE;
                            end
                            else if (al_need <= VAL_W'(nxt_h_reg))
                            begin
                                pos_next   = AW'(idx_p1);
                                idx_next   = AW'(count_reg);
                                state_next = S_SHR;
                            end
                            else
                            begin
                                idx_next   = AW'(idx_p1);
                                state_next = S_RDC;
                            end
                        end
                        M_APPEND:
                        begin
                            priority if (al_need > limit_v)
                            begin
                                done_next     = 1'b1;
                                busy_next     = 1'b0;
                                st_next       = ST_NOSPACE;
                                addr_out_next = '0;
                                state_next    = S_IDLE;
                            end
                            else if (count_reg >= MAX_C)
                            begin
                                done_next     = 1'b1;
                                busy_next     = 1'b0;
                                st_next       = ST_FULL;
                                addr_out_next = '0;
                                state_next    = S_IDLE;
                            end
                            else
                            begin
                                pos_next   = AW'(count_reg);
                                idx_next   = AW'(count_reg);
                                state_next = S_SHR;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // Open a slot: move entries up one place, top first
            S_SHR:
            begin
                if (idx_reg > pos_reg)
                begin
                    mem_raddr  = idx_reg - 1'b1;
                    state_next = S_SHW;
                end
                else
                    state_next = S_INS;
            end

            S_SHW:
            begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg;
                idx_next   = idx_reg - 1'b1;
                state_next = S_SHR;
            end

            S_INS:
            begin
                mem_we        = 1'b1;
                mem_waddr     = pos_reg;
                mem_whdr      = hdr_reg;
                mem_wsize     = size_reg;
                count_next    = count_reg + 1'b1;
                done_next     = 1'b1;
                busy_next     = 1'b0;
                st_next       = ST_OK;
                addr_out_next = data_reg;
                state_next    = S_IDLE;
            end

            S_RRD:
                state_next = S_RCMP;

            // Match the release header against each entry
            S_RCMP:
            begin
                priority if (rd_hdr == target_reg && idx_reg == '0)
                begin
                    head_free_next = 1'b1;
                    done_next      = 1'b1;
                    busy_next      = 1'b0;
                    st_next        = ST_OK;
                    addr_out_next  = '0;
                    state_next     = S_IDLE;
                end
                else if (rd_hdr == target_reg)
                    state_next = S_DRD;
                else if (idx_p1 < count_reg)
                begin
                    idx_next   = AW'(idx_p1);
                    state_next = S_RRD;
                end
                else
                begin
                    done_next     = 1'b1;
                    busy_next     = 1'b0;
                    st_next       = ST_UNKNOWN;
                    addr_out_next = '0;
                    state_next    = S_IDLE;
                end
            end

            // Close the gap: move entries down one place
            S_DRD:
            begin
                if (idx_p1 < count_reg)
                begin
                    mem_raddr  = AW'(idx_p1);
                    state_next = S_DWR;
                end
                else
                begin
                    count_next    = count_reg - 1'b1;
                    done_next     = 1'b1;
                    busy_next     = 1'b0;
                    st_next       = ST_OK;
                    addr_out_next = '0;
                    state_next    = S_IDLE;
                end
            end

            S_DWR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg;
                idx_next   = AW'(idx_p1);
                state_next = S_DRD;
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mode_reg       <= M_FIRST;
            idx_reg        <= '0;
            pos_reg        <= '0;
            count_reg      <= '0;
            head_free_reg  <= 1'b0;
            first_pend_reg <= 1'b1;
            head_addr_reg  <= '0;
            limit_reg      <= '1;
            size_reg       <= '0;
            target_reg     <= '0;
            cur_h_reg      <= '0;
            cur_s_reg      <= '0;
            nxt_h_reg      <= '0;
            hdr_reg        <= '0;
            data_reg       <= '0;
            busy_reg       <= 1'b0;
            done_reg       <= 1'b0;
            addr_out_reg   <= '0;
            st_reg         <= ST_OK;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            idx_reg        <= idx_next;
            pos_reg        <= pos_next;
            count_reg      <= count_next;
            head_free_reg  <= head_free_next;
            first_pend_reg <= first_pend_next;
            head_addr_reg  <= head_addr_next;
            limit_reg      <= limit_next;
            size_reg       <= size_next;
            target_reg     <= target_next;
            cur_h_reg      <= cur_h_next;
            cur_s_reg      <= cur_s_next;
            nxt_h_reg      <= nxt_h_next;
            hdr_reg        <= hdr_next;
            data_reg       <= data_next;
            busy_reg       <= busy_next;
            done_reg       <= done_next;
            addr_out_reg   <= addr_out_next;
            st_reg         <= st_next;
        end
    end

    assign busy         = busy_reg;
    assign done         = done_reg;
    assign data_address = addr_out_reg;
    assign status       = st_reg;
    assign cfg_ready    = 1'b1;

endmodule

/* rtl/core/ffha_checker.sv */
// Port-level checks for the first-fit heap allocator, bound to the top level.
// Depends on ffha_pkg and first_fit_heap_allocator_assert.svh.
`include "first_fit_heap_allocator_assert.svh"

module ffha_checker
    import ffha_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [2:0]  status,
    input logic [31:0] data_address
);

    `FFHA_ASSERT_SAME(a_done_not_busy, clk, rst_n, done, !busy, "result while still busy")
    `FFHA_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy || done, "transfer lost")
    `FFHA_ASSERT_SAME(a_fail_zero, clk, rst_n, done && status != ST_OK, data_address == 32'd0, "failed request returned an address")
    `FFHA_ASSERT_SAME(a_busy_ends, clk, rst_n, $fell(busy), done, "busy dropped without a result")

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .status       (status),
    .data_address (data_address)
);

/* verif/tb.sv */
// Self-checking testbench for first_fit_heap_allocator: directed and random
// allocate/release traffic checked against a cycle-free allocator predictor.
// Depends on ffha_pkg and the first_fit_heap_allocator RTL.
`timescale 1ns / 100ps

module tb;
    import ffha_pkg::*;

    localparam int          TABLE_DEPTH  = 64;
    localparam longint      HDR_BYTES    = 24;
    localparam longint      ALIGN        = 16;
    localparam longint      CYCLE_LIMIT  = 4000000;
    localparam logic [31:0] ALL_ONES     = 32'hFFFF_FFFF;

    typedef struct {
        logic        kind;
        logic [31:0] size;
        logic [31:0] addr;
    } alloc_req_t;

    typedef struct {
        logic [31:0] addr;
        logic [2:0]  st;
    } alloc_rsp_t;

    logic        clk             = 1'b0;
    logic        rst_n           = 1'b0;
    logic        start           = 1'b0;
    logic        req_type        = REQ_ALLOC;
    logic [31:0] req_size        = '0;
    logic [31:0] release_address = '0;
    logic        cfg_valid       = 1'b0;
    logic        cfg_index       = CFG_HEAP_BASE;
    logic [31:0] cfg_data        = '0;
    logic        busy;
    logic        done;
    logic [31:0] data_address;
    logic [2:0]  status;
    logic        cfg_ready;

    // Allocator mirror: table, head bookkeeping and register copies
    logic [31:0]     blk_hdr [TABLE_DEPTH];
    logic [31:0]     blk_size [TABLE_DEPTH];
    int              blk_count     = 0;
    bit              head_free     = 1'b0;
    bit              first_pending = 1'b1;
    logic [31:0]     head_addr     = '0;
    longint unsigned heap_lo       = 0;
    longint unsigned heap_hi       = 64'hFFFF_FFFF;

    alloc_req_t pending_reqs [$];
    alloc_rsp_t expected_rsps [$];
    bit         gaps_on   = 1'b1;
    int         gap_left  = 0;
    int         errors    = 0;
    longint     cycles    = 0;
    int         seen_by_status [5] = '{default: 0};
    int         releases_sent = 0;

    first_fit_heap_allocator uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .req_type        (req_type),
        .req_size        (req_size),
        .release_address (release_address),
        .done            (done),
        .data_address    (data_address),
        .status          (status),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("tb: mismatch at cycle %0d: %s", cycles, msg);
        errors++;
    endtask

    // Header address whose data address is the aligned one at or after hdr + header
    function automatic longint unsigned aligned_header(input longint unsigned hdr);
        longint unsigned data;
        begin
            data = hdr + HDR_BYTES;
            if (data % ALIGN != 0)
                data += ALIGN - (data % ALIGN);
            return data - HDR_BYTES;
        end
    endfunction

    function automatic void table_insert(input int pos, input longint unsigned hdr,
                                         input longint unsigned size);
        begin
            for (int k = blk_count; k > pos; k--)
            begin
                blk_hdr[k]  = blk_hdr[k-1];
                blk_size[k] = blk_size[k-1];
            end
            blk_hdr[pos]  = hdr[31:0];
            blk_size[pos] = size[31:0];
            blk_count++;
        end
    endfunction

    function automatic logic [2:0] predict_alloc(input longint unsigned size,
                                                 output longint unsigned addr);
        longint unsigned hdr, cur, cur_size, blk_end, nxt;
        bit alone;
        begin
            addr = 0;
            if (first_pending || blk_count == 0)
            begin
                hdr = aligned_header(head_addr);
                if (hdr + HDR_BYTES + size > heap_hi)
                    return ST_NOSPACE;
                blk_count = 0;
                table_insert(0, hdr, size);
                head_addr     = hdr[31:0];
                head_free     = 1'b0;
                first_pending = 1'b0;
                addr = hdr + HDR_BYTES;
                return ST_OK;
            end
            for (int i = 0; i < blk_count; i++)
            begin
                cur      = blk_hdr[i];
                cur_size = blk_size[i];
                // Reuse a freed head when it fits
                if (i == 0 && head_free)
                begin
                    alone = (blk_count == 1);
                    if (alone && cur + HDR_BYTES + size > heap_hi)
                        return ST_NOSPACE;
                    if (alone || size <= cur_size)
                    begin
                        blk_size[0] = size[31:0];
                        head_free   = 1'b0;
                        addr = cur + HDR_BYTES;
                        return ST_OK;
                    end
                end
                // Try the hole up to the next header
                if (i + 1 < blk_count)
                begin
                    blk_end = cur + HDR_BYTES + cur_size;
                    nxt     = blk_hdr[i+1];
                    if (blk_end < nxt)
                    begin
                        hdr = aligned_header(blk_end);
                        if (hdr + HDR_BYTES + size <= nxt)
                        begin
                            if (blk_count >= TABLE_DEPTH)
                                return ST_FULL;
                            table_insert(i + 1, hdr, size);
                            addr = hdr + HDR_BYTES;
                            return ST_OK;
                        end
                    end
                    else if (blk_end > nxt)
                        return ST_OVERLAP;
                end
            end
            // Append after the last block
            cur = blk_hdr[blk_count-1];
            hdr = aligned_header(cur + HDR_BYTES + longint'(blk_size[blk_count-1]));
            if (hdr + HDR_BYTES + size > heap_hi)
                return ST_NOSPACE;
            if (blk_count >= TABLE_DEPTH)
                return ST_FULL;
            table_insert(blk_count, hdr, size);
            addr = hdr + HDR_BYTES;
            return ST_OK;
        end
    endfunction

    function automatic logic [2:0] predict_release(input longint unsigned mem);
        longint unsigned hdr;
        begin
            if (first_pending || blk_count == 0 || mem < HDR_BYTES)
                return ST_UNKNOWN;
            hdr = mem - HDR_BYTES;
            for (int i = 0; i < blk_count; i++)
            begin
                if (longint'(blk_hdr[i]) == hdr)
                begin
                    if (i == 0)
                    begin
                        head_free = 1'b1;
                        return ST_OK;
                    end
                    for (int k = i; k + 1 < blk_count; k++)
                    begin
                        blk_hdr[k]  = blk_hdr[k+1];
                        blk_size[k] = blk_size[k+1];
                    end
                    blk_count--;
                    return ST_OK;
                end
            end
            return ST_UNKNOWN;
        end
    endfunction

    function automatic alloc_rsp_t predict_response(input alloc_req_t r);
        alloc_rsp_t      rsp;
        longint unsigned addr;
        begin
            addr = 0;
            if (r.kind == REQ_ALLOC)
                rsp.st = predict_alloc(longint'(r.size), addr);
            else
                rsp.st = predict_release(longint'(r.addr));
            rsp.addr = (rsp.st == ST_OK) ? addr[31:0] : 32'd0;
            return rsp;
        end
    endfunction

    // Driver: hold start until the transfer, then advance or idle a burst
    always @(posedge clk)
    begin
        bit         taken;
        bit         next_start;
        alloc_req_t nxt;
        if (rst_n)
        begin
            taken = start && !busy;
            if (taken)
            begin
                expected_rsps.push_back(predict_response(pending_reqs.pop_front()));
            end
            next_start = start && !taken;
            if (!next_start)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_reqs.size() > 0)
                begin
                    if (gaps_on && $urandom_range(0, 3) == 0)
                        gap_left = $urandom_range(1, 6);
                    else
                    begin
                        nxt = pending_reqs[0];
                        req_type        <= nxt.kind;
                        req_size        <= nxt.size;
                        release_address <= nxt.addr;
                        next_start = 1'b1;
                    end
                end
            end
            start <= next_start;
        end
    end

    // Monitor: compare every strobed result with the oldest expectation
    always @(posedge clk)
    begin
        alloc_rsp_t exp_rsp;
        cycles++;
        if (rst_n && done)
        begin
            if (expected_rsps.size() == 0)
                report_mismatch($sformatf("unexpected result addr=%h status=%0d",
                                          data_address, status));
            else
            begin
                exp_rsp = expected_rsps.pop_front();
                if (data_address !== exp_rsp.addr)
                    report_mismatch($sformatf("data_address %h, expected %h",
                                              data_address, exp_rsp.addr));
                if (status !== exp_rsp.st)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              status, exp_rsp.st));
                if (exp_rsp.st <= ST_FULL)
                    seen_by_status[exp_rsp.st]++;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: timeout after %0d cycles", cycles);
            $display("tb: FAIL");
            $finish;
        end
    end

    task automatic wait_idle();
        while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || start)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_HEAP_BASE)
        begin
            heap_lo = value;
            if (first_pending)
                head_addr = value;
        end
        else
            heap_hi = value;
    endtask

    // Queue one request and hold off until its result has come
    task automatic send_sync(input logic kind, input logic [31:0] size,
                             input logic [31:0] addr);
        alloc_req_t r;
        r.kind = kind;
        r.size = size;
        r.addr = addr;
        pending_reqs.push_back(r);
        if (kind == REQ_RELEASE)
            releases_sent++;
        wait_idle();
    endtask

    function automatic logic [31:0] live_address(input int k);
        return blk_hdr[k] + 32'(HDR_BYTES);
    endfunction

    // Random traffic: mostly small allocations and releases of live blocks
    task automatic send_random(input int count, input int release_pct);
        alloc_req_t r;
        int         pick;
        for (int n = 0; n < count; n++)
        begin
            while (pending_reqs.size() >= 2)
                @(posedge clk);
            r.size = $urandom;
            r.addr = $urandom;
            pick   = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < release_pct)
            begin
                r.kind = REQ_RELEASE;
                releases_sent++;
                if (pick < 80 && blk_count > 0)
                    r.addr = live_address($urandom_range(0, blk_count - 1));
                else if (pick < 90 && blk_count > 0)
                    r.addr = live_address($urandom_range(0, blk_count - 1))
                             + $urandom_range(1, 15);
            end
            else
            begin
                r.kind = REQ_ALLOC;
                if (pick < 80)
                    r.size = $urandom_range(0, 160);
                else if (pick < 90)
                    r.size = $urandom_range(0, 16384);
            end
            pending_reqs.push_back(r);
            // Occasionally drain completely before going on
            if ($urandom_range(0, 99) == 0)
                wait_idle();
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Heap start near the top: first allocation cannot fit
        write_reg(CFG_HEAP_BASE, 32'hFFFF_FFF0);
        send_sync(REQ_ALLOC, 32'd0, 32'd0);
        send_sync(REQ_RELEASE, 32'd0, 32'h0000_1000);
        // Unaligned heap start with a tight end
        write_reg(CFG_HEAP_BASE, 32'h0000_1003);
        write_reg(CFG_HEAP_LIMIT, 32'h0000_1403);
        send_sync(REQ_ALLOC, ALL_ONES, 32'd0);
        send_sync(REQ_ALLOC, 32'd0, ALL_ONES);
        send_sync(REQ_ALLOC, 32'd40, 32'd0);
        send_sync(REQ_ALLOC, 32'd100, 32'd0);
        send_sync(REQ_ALLOC, 32'd7, 32'd0);
        // Open a hole in the middle and refill it
        send_sync(REQ_RELEASE, 32'd0, live_address(2));
        send_sync(REQ_ALLOC, 32'd60, 32'd0);
        send_sync(REQ_ALLOC, 32'd20, 32'd0);
        // Freed head: release twice, too-large request walks on, small one reuses
        send_sync(REQ_RELEASE, 32'd0, live_address(0));
        send_sync(REQ_RELEASE, 32'd0, live_address(0));
        send_sync(REQ_ALLOC, 32'd500, 32'd0);
        send_sync(REQ_ALLOC, 32'd0, 32'd0);
        // Bad release addresses
        send_sync(REQ_RELEASE, ALL_ONES, 32'd0);
        send_sync(REQ_RELEASE, 32'd0, ALL_ONES);
        send_sync(REQ_RELEASE, 32'd0, live_address(1) + 32'd1);
        send_sync(REQ_RELEASE, 32'd0, 32'd23);
        // Heap end at zero: only holes can fit; late heap start writes change nothing
        write_reg(CFG_HEAP_LIMIT, 32'd0);
        write_reg(CFG_HEAP_BASE, 32'd0);
        send_sync(REQ_ALLOC, 32'd0, 32'd0);
        send_sync(REQ_ALLOC, 32'd16, 32'd0);

        // Tight heap: frequent no-space answers
        write_reg(CFG_HEAP_LIMIT, 32'h0000_3000);
        write_reg(CFG_HEAP_BASE, ALL_ONES);
        send_random(220, 40);
        wait_idle();

        // Open heap: the table fills up
        write_reg(CFG_HEAP_LIMIT, ALL_ONES);
        send_random(300, 30);
        wait_idle();

        // Medium heap, no idling on the request side
        write_reg(CFG_HEAP_LIMIT, 32'h0001_0000);
        gaps_on  = 1'b0;
        gap_left = 0;
        send_random(160, 50);
        wait_idle();
        repeat (10) @(posedge clk);

        $display("tb: %0d releases sent; results ok %0d, no-space %0d, overlap %0d,",
                 releases_sent, seen_by_status[ST_OK], seen_by_status[ST_NOSPACE],
                 seen_by_status[ST_OVERLAP]);
        $display("tb: unknown-address %0d, table-full %0d; %0d mismatches in %0d cycles",
                 seen_by_status[ST_UNKNOWN], seen_by_status[ST_FULL], errors, cycles);
        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/ffha_pkg.sv
rtl/core/ffha_table.sv
rtl/core/ffha_align.sv
rtl/core/first_fit_heap_allocator.sv
rtl/core/ffha_checker.sv
verif/tb.sv
